// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the UTF-8 printable-text validator.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked implication check, switched off while reset is held.
`define ASSERT_IMPLY(label, cond, prop, msg) \
    `ASSERT_CLK(label, (cond) |-> (prop), msg)

`endif

// ===== hdl/u8pv_pkg.sv =====
// Types and byte constants for the UTF-8 printable-text validator.
// Depends on nothing; used by u8pv_byte_check and utf8_printable_validator.
package u8pv_pkg;

    // Kind of the first fault found in a text.
    typedef enum logic [2:0] {
        FAULT_NONE  = 3'd0,
        FAULT_LEAD  = 3'd1,
        FAULT_CONT  = 3'd2,
        FAULT_TRUNC = 3'd3,
        FAULT_CTRL  = 3'd4
    } t_fault;

    // Per-text tracking state.
    typedef struct packed {
        logic [1:0] pending;
        logic [7:0] low_bound;
        logic [7:0] high_bound;
        t_fault     fault;
    } t_text_state;

    // Ordinary continuation range.
    localparam logic [7:0] C_CONT_LO     = 8'h80;
    localparam logic [7:0] C_CONT_HI     = 8'hbf;
    // Lead byte classes.
    localparam logic [7:0] C_LEAD2_LO    = 8'hc2;
    localparam logic [7:0] C_LEAD2_HI    = 8'hdf;
    localparam logic [7:0] C_LEAD3_LO    = 8'he0;
    localparam logic [7:0] C_LEAD3_HI    = 8'hef;
    localparam logic [7:0] C_LEAD4_LO    = 8'hf0;
    localparam logic [7:0] C_LEAD4_HI    = 8'hf4;
    // Leads that narrow the first continuation.
    localparam logic [7:0] C_LEAD_E0     = 8'he0;
    localparam logic [7:0] C_LEAD_ED     = 8'hed;
    localparam logic [7:0] C_LEAD_F0     = 8'hf0;
    localparam logic [7:0] C_LEAD_F4     = 8'hf4;
    localparam logic [7:0] C_E0_LO       = 8'ha0;
    localparam logic [7:0] C_ED_HI       = 8'h9f;
    localparam logic [7:0] C_F0_LO       = 8'h90;
    localparam logic [7:0] C_F4_HI       = 8'h8f;
    // Control characters.
    localparam logic [7:0] C_ASCII_HI    = 8'h7f;
    localparam logic [7:0] C_SPACE       = 8'h20;
    localparam logic [7:0] C_DEL         = 8'h7f;

    localparam t_text_state C_STATE_RESET = '{
        pending:    2'd0,
        low_bound:  C_CONT_LO,
        high_bound: C_CONT_HI,
        fault:      FAULT_NONE
    };

endpackage

// ===== hdl/u8pv_byte_check.sv =====
// Combinational check of one text byte against the per-text tracking state.
// Depends on u8pv_pkg for the state type, fault codes and byte constants.
module u8pv_byte_check
    import u8pv_pkg::*;
(
    input  t_text_state i_state,
    input  logic [7:0]  i_byte,
    input  logic        i_final,
    input  logic        i_reject_controls,
    output t_text_state o_next_state,
    output t_fault      o_fault
);

    t_text_state w_upd;

    // Classify the byte and update the expected sequence.
    always_comb begin
        w_upd = i_state;
        if (i_state.fault != FAULT_NONE) begin
            w_upd = i_state;
        end else if (i_state.pending != 2'd0) begin
            if (i_byte < i_state.low_bound || i_byte > i_state.high_bound) begin
                w_upd.fault = FAULT_CONT;
            end else begin
                w_upd.pending    = i_state.pending - 2'd1;
                w_upd.low_bound  = C_CONT_LO;
                w_upd.high_bound = C_CONT_HI;
            end
        end else if (i_byte <= C_ASCII_HI) begin
            if (i_reject_controls && (i_byte < C_SPACE || i_byte == C_DEL)) begin
                w_upd.fault = FAULT_CTRL;
            end
        end else if (i_byte inside {[C_LEAD2_LO:C_LEAD2_HI]}) begin
            w_upd.pending    = 2'd1;
            w_upd.low_bound  = C_CONT_LO;
            w_upd.high_bound = C_CONT_HI;
        end else if (i_byte inside {[C_LEAD3_LO:C_LEAD3_HI]}) begin
            w_upd.pending    = 2'd2;
            w_upd.low_bound  = (i_byte == C_LEAD_E0) ? C_E0_LO : C_CONT_LO;
            w_upd.high_bound = (i_byte == C_LEAD_ED) ? C_ED_HI : C_CONT_HI;
        end else if (i_byte inside {[C_LEAD4_LO:C_LEAD4_HI]}) begin
            w_upd.pending    = 2'd3;
            w_upd.low_bound  = (i_byte == C_LEAD_F0) ? C_F0_LO : C_CONT_LO;
            w_upd.high_bound = (i_byte == C_LEAD_F4) ? C_F4_HI : C_CONT_HI;
        end else begin
            w_upd.fault = FAULT_LEAD;
        end
    end

    // On the final byte, settle the verdict and start a fresh text.
    always_comb begin
        o_fault      = w_upd.fault;
        o_next_state = w_upd;
        if (i_final) begin
            if (w_upd.fault == FAULT_NONE && w_upd.pending != 2'd0) begin
                o_fault = FAULT_TRUNC;
            end
            o_next_state = C_STATE_RESET;
        end
    end

endmodule

// ===== hdl/utf8_printable_validator.sv =====
// Top level of the streaming strict UTF-8 validator with printable-text check.
// Depends on u8pv_pkg, u8pv_byte_check and assert_macros.svh.
//
// Usage:
//   The input channel (i_valid, o_stall, i_text_byte, i_final_byte) carries
//   one byte of text per transfer; i_final_byte marks the last byte. The
//   output channel (o_valid, i_stall, o_text_valid, o_fault_kind) carries one
//   verdict per text, produced by the transfer of its final byte.
//   A byte is registered at its transfer and checked from the input register;
//   when a final byte advances, its verdict is registered and o_valid rises.
//   One byte can be taken every cycle while o_stall is low; the only feedback
//   loop is the small per-text state update in u8pv_byte_check. While the
//   receiver stalls, the verdict holds and non-final bytes keep flowing; a
//   final byte waits in the input register and o_stall is raised until the
//   held verdict has been taken. i_cfg_wr_en with i_cfg_wr_data sets the
//   control-byte rejection mode; the user writes it only between texts, and
//   the block does not enforce this. Synchronous active-low reset empties
//   both registers, clears the text state and turns control-byte rejection on.
module utf8_printable_validator
    import u8pv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_text_valid,
    output logic [2:0] o_fault_kind
);

    logic        r_reject_controls;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_final;
    t_text_state r_state;
    t_text_state n_state;
    t_fault      w_fault;
    logic        r_out_valid;
    logic        r_out_text_valid;
    t_fault      r_out_fault;
    logic        w_advance;
    logic        w_out_take;
    logic        w_in_take;

    // Handshake control: a final byte advances only into a result register that is empty or being taken.
    assign w_out_take = r_out_valid && !i_stall;
    assign w_advance  = r_in_valid && (!r_in_final || !r_out_valid || !i_stall);
    assign o_stall    = r_in_valid && !w_advance;
    assign w_in_take  = i_valid && !o_stall;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reject_controls <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_reject_controls <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte  <= i_text_byte;
            r_in_final <= i_final_byte;
        end
    end

    u8pv_byte_check u_check (
        .i_state           (r_state),
        .i_byte            (r_in_byte),
        .i_final           (r_in_final),
        .i_reject_controls (r_reject_controls),
        .o_next_state      (n_state),
        .o_fault           (w_fault)
    );

    // Per-text tracking state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_STATE_RESET;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_final) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_final) begin
            r_out_text_valid <= (w_fault == FAULT_NONE);
            r_out_fault      <= w_fault;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_text_valid = r_out_text_valid;
    assign o_fault_kind = r_out_fault;

`include "assert_macros.svh"

    // The verdict flag agrees with the fault code.
    `ASSERT_IMPLY(a_verdict_matches, r_out_valid, r_out_text_valid == (r_out_fault == FAULT_NONE), "verdict and fault kind disagree")
    // With nothing pending, the bounds are the ordinary continuation range.
    `ASSERT_IMPLY(a_idle_bounds, r_state.pending == 2'd0, r_state.low_bound == C_CONT_LO && r_state.high_bound == C_CONT_HI, "bounds not reset with no pending bytes")
    // A final byte meeting a stalled, full result register must hold off input.
    `ASSERT_IMPLY(a_final_blocks, r_in_valid && r_in_final && r_out_valid && i_stall, o_stall, "final byte overran a held verdict")
    // A held verdict is not lost while the receiver stalls.
    `ASSERT_IMPLY(a_verdict_held, r_out_valid && i_stall, ##1 r_out_valid, "held verdict dropped")

endmodule
